### hdl/qpat_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qpat_pkg
// Shared types and constants of the quaternion PD attitude torque block.
// ----------------------------------------------------------------------------
package qpat_pkg;

    // Unit magnitude in Q1.14.
    localparam int Q_ONE = 16384;

    // Quotient bits produced by each normalizing divider.
    localparam int QUO_W = 16;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_KP_X   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KP_Y   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KP_Z   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KD_X   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_KD_Y   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_KD_Z   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMITS = 3'd6;

    // Unit quaternion in Q1.14.
    typedef struct packed {
        logic signed [15:0] w;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
    } t_quat;

endpackage

### hdl/qpat_isqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qpat_isqrt
// Pipelined integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module qpat_isqrt #(
    parameter int N = 31
) (
    input  logic           i_clk,
    input  logic           i_en,
    input  logic [2*N-1:0] i_val,
    output logic [N-1:0]   o_root
);

    logic [N+1:0]   r_rem  [N];
    logic [N-1:0]   r_root [N];
    logic [2*N-1:0] r_val  [N];

    logic [N+1:0]   n_rem  [N];
    logic [N-1:0]   n_root [N];
    logic [2*N-1:0] n_val  [N];

    logic [N+1:0]   s_rem  [N];
    logic [N-1:0]   s_root [N];
    logic [2*N-1:0] s_val  [N];
    logic [N+1:0]   w_rem_t [N];
    logic [N+1:0]   w_trial [N];

    always_comb begin
        s_rem[0]  = '0;
        s_root[0] = '0;
        s_val[0]  = i_val;
        for (int k = 1; k < N; k++) begin
            s_rem[k]  = r_rem[k-1];
            s_root[k] = r_root[k-1];
            s_val[k]  = r_val[k-1];
        end
        for (int k = 0; k < N; k++) begin
            // The remainder stays below 2^N before the last step.
            w_rem_t[k] = {s_rem[k][N-1:0], s_val[k][2*N-1 -: 2]};
            w_trial[k] = {s_root[k], 2'b01};
            if (w_rem_t[k] >= w_trial[k]) begin
                n_rem[k]  = w_rem_t[k] - w_trial[k];
                n_root[k] = {s_root[k][N-2:0], 1'b1};
            end else begin
                n_rem[k]  = w_rem_t[k];
                n_root[k] = {s_root[k][N-2:0], 1'b0};
            end
            n_val[k] = s_val[k] << 2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < N; k++) begin
                r_rem[k]  <= n_rem[k];
                r_root[k] <= n_root[k];
                r_val[k]  <= n_val[k];
            end
        end
    end

    assign o_root = r_root[N-1];

endmodule

### hdl/qpat_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qpat_div
// Pipelined restoring divider, one quotient bit per stage.
// The quotient must fit in QW bits.
// ----------------------------------------------------------------------------
module qpat_div #(
    parameter int DW = 45,
    parameter int MW = 31,
    parameter int QW = 16
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [DW-1:0] i_num,
    input  logic [MW-1:0] i_den,
    output logic [QW-1:0] o_quo
);

    logic [MW-1:0] r_rem [QW];
    logic [MW-1:0] r_den [QW];
    logic [QW-1:0] r_lo  [QW];
    logic [QW-1:0] r_q   [QW];

    logic [MW-1:0] n_rem [QW];
    logic [QW-1:0] n_lo  [QW];
    logic [QW-1:0] n_q   [QW];

    logic [MW-1:0] s_rem [QW];
    logic [MW-1:0] s_den [QW];
    logic [QW-1:0] s_lo  [QW];
    logic [QW-1:0] s_q   [QW];
    logic [MW:0]   w_t   [QW];
    logic [MW:0]   w_d   [QW];
    logic [DW-1:0] w_hi;

    assign w_hi = i_num >> QW;

    always_comb begin
        s_rem[0] = w_hi[MW-1:0];
        s_den[0] = i_den;
        s_lo[0]  = i_num[QW-1:0];
        s_q[0]   = '0;
        for (int k = 1; k < QW; k++) begin
            s_rem[k] = r_rem[k-1];
            s_den[k] = r_den[k-1];
            s_lo[k]  = r_lo[k-1];
            s_q[k]   = r_q[k-1];
        end
        for (int k = 0; k < QW; k++) begin
            w_t[k] = {s_rem[k], s_lo[k][QW-1]};
            if (w_t[k] >= {1'b0, s_den[k]}) begin
                w_d[k] = w_t[k] - {1'b0, s_den[k]};
                n_q[k] = {s_q[k][QW-2:0], 1'b1};
            end else begin
                w_d[k] = w_t[k];
                n_q[k] = {s_q[k][QW-2:0], 1'b0};
            end
            n_rem[k] = w_d[k][MW-1:0];
            n_lo[k]  = s_lo[k] << 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < QW; k++) begin
                r_rem[k] <= n_rem[k];
                r_den[k] <= s_den[k];
                r_lo[k]  <= n_lo[k];
                r_q[k]   <= n_q[k];
            end
        end
    end

    assign o_quo = r_q[QW-1];

endmodule

### hdl/qpat_norm.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qpat_norm
// Quaternion normalizer to Q1.14: sum of squares, square root, four
// rounded divides and a clamp. A zero quaternion gives the identity.
// Sideband bits travel alongside.
// ----------------------------------------------------------------------------
module qpat_norm #(
    parameter int CW        = 16,
    parameter int SQ_SHIFT  = 28,
    parameter int NUM_SHIFT = 28,
    parameter int SW        = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic [3:0][CW-1:0]   i_comp,
    input  logic [SW-1:0]        i_side,
    output logic                 o_valid,
    output qpat_pkg::t_quat      o_quat,
    output logic [SW-1:0]        o_side
);

    localparam int SUMW = 2 * CW + 1;
    localparam int RN   = (SUMW + SQ_SHIFT + 1) / 2;
    localparam int VW   = 2 * RN;
    localparam int DW   = CW + NUM_SHIFT + 1;
    localparam int QW   = qpat_pkg::QUO_W;
    localparam int AW   = 4 * CW + 5 + SW;
    localparam int BW   = 5 + SW;

    // Stage 1: squares and magnitudes.
    logic [3:0][CW-1:0]   w_mag;
    logic [3:0][2*CW-1:0] w_sq;
    logic [3:0]           w_sgn;

    logic                 r1_v;
    logic [3:0][2*CW-1:0] r1_sq;
    logic [3:0][CW-1:0]   r1_mag;
    logic [3:0]           r1_sgn;
    logic                 r1_zero;
    logic [SW-1:0]        r1_side;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            w_sgn[i] = i_comp[i][CW-1];
            w_mag[i] = w_sgn[i] ? (~i_comp[i] + 1'b1) : i_comp[i];
            w_sq[i]  = $signed(i_comp[i]) * $signed(i_comp[i]);
        end
    end

    // Stage 2: sum of squares.
    logic                 r2_v;
    logic [SUMW-1:0]      r2_sum;
    logic [3:0][CW-1:0]   r2_mag;
    logic [3:0]           r2_sgn;
    logic                 r2_zero;
    logic [SW-1:0]        r2_side;

    // Square root and the line that runs beside it.
    logic [VW-1:0]        w_sq_in;
    logic [RN-1:0]        w_root;
    logic [AW-1:0]        w_a_in;
    logic [AW-1:0]        w_a_out;
    logic [AW-1:0]        r_a [RN];
    logic [RN-1:0]        r_a_v;
    logic [3:0][CW-1:0]   w_a_mag;
    logic [3:0]           w_a_sgn;
    logic                 w_a_zero;
    logic [SW-1:0]        w_a_side;

    assign w_sq_in = VW'(r2_sum) << SQ_SHIFT;
    assign w_a_in  = {r2_mag, r2_sgn, r2_zero, r2_side};
    assign w_a_out = r_a[RN-1];
    assign w_a_mag  = w_a_out[AW-1 -: 4*CW];
    assign w_a_sgn  = w_a_out[SW+4 -: 4];
    assign w_a_zero = w_a_out[SW];
    assign w_a_side = w_a_out[SW-1:0];

    qpat_isqrt #(.N(RN)) u_isqrt (
        .i_clk  (i_clk),
        .i_en   (i_en),
        .i_val  (w_sq_in),
        .o_root (w_root)
    );

    // Stage 3: rounded numerators.
    logic                 r3_v;
    logic [DW-1:0]        r3_num [4];
    logic [RN-1:0]        r3_den;
    logic [3:0]           r3_sgn;
    logic                 r3_zero;
    logic [SW-1:0]        r3_side;

    // Dividers and the line beside them.
    logic [QW-1:0]        w_quo [4];
    logic [BW-1:0]        r_b [QW];
    logic [QW-1:0]        r_b_v;
    logic [BW-1:0]        w_b_out;

    assign w_b_out = r_b[QW-1];

    for (genvar g = 0; g < 4; g++) begin : g_div
        qpat_div #(.DW(DW), .MW(RN), .QW(QW)) u_div (
            .i_clk (i_clk),
            .i_en  (i_en),
            .i_num (r3_num[g]),
            .i_den (r3_den),
            .o_quo (w_quo[g])
        );
    end

    // Stage 4: clamp and sign.
    logic [15:0]          w_qc  [4];
    logic [15:0]          w_out [4];
    logic                 r4_v;
    qpat_pkg::t_quat      r4_quat;
    logic [SW-1:0]        r4_side;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            w_qc[i] = (w_quo[i] > 16'(qpat_pkg::Q_ONE)) ? 16'(qpat_pkg::Q_ONE) : w_quo[i];
            if (w_b_out[SW]) begin
                w_out[i] = (i == 0) ? 16'(qpat_pkg::Q_ONE) : 16'd0;
            end else begin
                w_out[i] = w_b_out[SW+1+i] ? (~w_qc[i] + 1'b1) : w_qc[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v  <= 1'b0;
            r2_v  <= 1'b0;
            r_a_v <= '0;
            r3_v  <= 1'b0;
            r_b_v <= '0;
            r4_v  <= 1'b0;
        end else if (i_en) begin
            r1_v  <= i_valid;
            r2_v  <= r1_v;
            r_a_v <= {r_a_v[RN-2:0], r2_v};
            r3_v  <= r_a_v[RN-1];
            r_b_v <= {r_b_v[QW-2:0], r3_v};
            r4_v  <= r_b_v[QW-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_sq   <= w_sq;
            r1_mag  <= w_mag;
            r1_sgn  <= w_sgn;
            r1_zero <= (w_mag == '0);
            r1_side <= i_side;

            r2_sum  <= SUMW'(r1_sq[0]) + SUMW'(r1_sq[1]) + SUMW'(r1_sq[2]) + SUMW'(r1_sq[3]);
            r2_mag  <= r1_mag;
            r2_sgn  <= r1_sgn;
            r2_zero <= r1_zero;
            r2_side <= r1_side;

            r_a[0] <= w_a_in;
            for (int k = 1; k < RN; k++) begin
                r_a[k] <= r_a[k-1];
            end

            // Adding half the divisor makes the truncating divide round.
            for (int i = 0; i < 4; i++) begin
                r3_num[i] <= (DW'(w_a_mag[i]) << NUM_SHIFT) + DW'(w_root >> 1);
            end
            r3_den  <= w_root;
            r3_sgn  <= w_a_sgn;
            r3_zero <= w_a_zero;
            r3_side <= w_a_side;

            r_b[0] <= {r3_sgn, r3_zero, r3_side};
            for (int k = 1; k < QW; k++) begin
                r_b[k] <= r_b[k-1];
            end

            r4_quat.w <= w_out[0];
            r4_quat.x <= w_out[1];
            r4_quat.y <= w_out[2];
            r4_quat.z <= w_out[3];
            r4_side   <= w_b_out[SW-1:0];
        end
    end

    assign o_valid = r4_v;
    assign o_quat  = r4_quat;
    assign o_side  = r4_side;

endmodule

### hdl/quaternion_pd_attitude_torque.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quaternion_pd_attitude_torque
// Quaternion-feedback PD attitude controller: normalizes the commanded and
// measured quaternions, forms the error quaternion on the short path,
// renormalizes it and computes the clamped per-axis torque.
//
//   Channel   Handshake                 Payload
//   input     i_valid / o_ready         i_cmd_*, i_att_*, i_rate_*
//   output    o_valid / i_ready         o_torque_*, o_err_*
//   config    i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// One beat is taken per cycle while o_ready is high; the path from input to
// output runs through two chains of square root (31 and 33 stages) and
// divide (16 stages each) in the normalizers. Reset is synchronous, clears the
// valid bits and the gains and limits, and holds both ready outputs low.
// When the output stalls, a skid register takes the beat in flight and the
// pipeline freezes from the next cycle on.
// ----------------------------------------------------------------------------
module quaternion_pd_attitude_torque (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic signed [15:0]                  i_cmd_w,
    input  logic signed [15:0]                  i_cmd_x,
    input  logic signed [15:0]                  i_cmd_y,
    input  logic signed [15:0]                  i_cmd_z,
    input  logic signed [15:0]                  i_att_w,
    input  logic signed [15:0]                  i_att_x,
    input  logic signed [15:0]                  i_att_y,
    input  logic signed [15:0]                  i_att_z,
    input  logic signed [15:0]                  i_rate_x,
    input  logic signed [15:0]                  i_rate_y,
    input  logic signed [15:0]                  i_rate_z,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [15:0]                  o_torque_x,
    output logic signed [15:0]                  o_torque_y,
    output logic signed [15:0]                  o_torque_z,
    output logic [14:0]                         o_err_w,
    output logic signed [15:0]                  o_err_x,
    output logic signed [15:0]                  o_err_y,
    output logic signed [15:0]                  o_err_z,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [qpat_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [qpat_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    // Configuration registers.
    logic [2:0][15:0] r_kp;
    logic [2:0][15:0] r_kd;
    logic [47:0]      r_lim;

    assign o_cfg_ready = i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp  <= '0;
            r_kd  <= '0;
            r_lim <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                qpat_pkg::CFG_KP_X:   r_kp[0] <= i_cfg_data[15:0];
                qpat_pkg::CFG_KP_Y:   r_kp[1] <= i_cfg_data[15:0];
                qpat_pkg::CFG_KP_Z:   r_kp[2] <= i_cfg_data[15:0];
                qpat_pkg::CFG_KD_X:   r_kd[0] <= i_cfg_data[15:0];
                qpat_pkg::CFG_KD_Y:   r_kd[1] <= i_cfg_data[15:0];
                qpat_pkg::CFG_KD_Z:   r_kd[2] <= i_cfg_data[15:0];
                qpat_pkg::CFG_LIMITS: r_lim   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Global pipeline enable, driven only by the registered skid state.
    logic r_sk_v;
    logic w_en;

    assign w_en    = !r_sk_v;
    assign o_ready = w_en & i_rst_n;

    // Input normalization.
    logic            w_c_v;
    logic            w_a_v;
    qpat_pkg::t_quat w_c_q;
    qpat_pkg::t_quat w_a_q;
    logic [31:0]     w_c_side;
    logic [15:0]     w_a_side;

    qpat_norm #(.CW(16), .SQ_SHIFT(28), .NUM_SHIFT(28), .SW(32)) u_norm_cmd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_valid),
        .i_comp  ({i_cmd_z, i_cmd_y, i_cmd_x, i_cmd_w}),
        .i_side  ({i_rate_y, i_rate_x}),
        .o_valid (w_c_v),
        .o_quat  (w_c_q),
        .o_side  (w_c_side)
    );

    qpat_norm #(.CW(16), .SQ_SHIFT(28), .NUM_SHIFT(28), .SW(16)) u_norm_att (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_valid),
        .i_comp  ({i_att_z, i_att_y, i_att_x, i_att_w}),
        .i_side  (i_rate_z),
        .o_valid (w_a_v),
        .o_quat  (w_a_q),
        .o_side  (w_a_side)
    );

    // Error quaternion conj(att) * cmd.
    logic signed [15:0] w_a [4];
    logic signed [15:0] w_c [4];

    always_comb begin
        w_a[0] = w_a_q.w;
        w_a[1] = w_a_q.x;
        w_a[2] = w_a_q.y;
        w_a[3] = w_a_q.z;
        w_c[0] = w_c_q.w;
        w_c[1] = w_c_q.x;
        w_c[2] = w_c_q.y;
        w_c[3] = w_c_q.z;
    end

    logic               r_p1_v;
    logic signed [31:0] r_p1_pr [4][4];
    logic [47:0]        r_p1_rate;
    logic               r_p2_v;
    logic signed [31:0] r_p2_e [4];
    logic [47:0]        r_p2_rate;
    logic               r_p3_v;
    logic [3:0][31:0]   r_p3_e;
    logic [47:0]        r_p3_rate;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_v <= 1'b0;
            r_p2_v <= 1'b0;
            r_p3_v <= 1'b0;
        end else if (w_en) begin
            r_p1_v <= w_c_v & w_a_v;
            r_p2_v <= r_p1_v;
            r_p3_v <= r_p2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 4; i++) begin
                for (int j = 0; j < 4; j++) begin
                    r_p1_pr[i][j] <= w_a[i] * w_c[j];
                end
            end
            r_p1_rate <= {w_a_side, w_c_side};

            r_p2_e[0] <= r_p1_pr[0][0] + r_p1_pr[1][1] + r_p1_pr[2][2] + r_p1_pr[3][3];
            r_p2_e[1] <= r_p1_pr[0][1] - r_p1_pr[1][0] - r_p1_pr[2][3] + r_p1_pr[3][2];
            r_p2_e[2] <= r_p1_pr[0][2] + r_p1_pr[1][3] - r_p1_pr[2][0] - r_p1_pr[3][1];
            r_p2_e[3] <= r_p1_pr[0][3] - r_p1_pr[1][2] + r_p1_pr[2][1] - r_p1_pr[3][0];
            r_p2_rate <= r_p1_rate;

            // Take the short rotation: flip the whole quaternion if w < 0.
            for (int i = 0; i < 4; i++) begin
                r_p3_e[i] <= r_p2_e[0][31] ? (~r_p2_e[i] + 1'b1) : r_p2_e[i];
            end
            r_p3_rate <= r_p2_rate;
        end
    end

    // Error normalization.
    logic            w_e_v;
    qpat_pkg::t_quat w_e_q;
    logic [47:0]     w_e_rate;

    qpat_norm #(.CW(32), .SQ_SHIFT(0), .NUM_SHIFT(14), .SW(48)) u_norm_err (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_p3_v),
        .i_comp  (r_p3_e),
        .i_side  (r_p3_rate),
        .o_valid (w_e_v),
        .o_quat  (w_e_q),
        .o_side  (w_e_rate)
    );

    logic signed [15:0] w_ev [3];

    always_comb begin
        w_ev[0] = w_e_q.x;
        w_ev[1] = w_e_q.y;
        w_ev[2] = w_e_q.z;
    end

    // Torque stages.
    logic               r_t1_v;
    logic signed [32:0] r_t1_pp [3];
    logic signed [32:0] r_t1_dd [3];
    qpat_pkg::t_quat    r_t1_err;
    logic               r_t2_v;
    logic signed [35:0] r_t2_t22 [3];
    qpat_pkg::t_quat    r_t2_err;
    logic               r_t3_v;
    logic [2:0]         r_t3_sgn;
    logic [35:0]        r_t3_mag [3];
    qpat_pkg::t_quat    r_t3_err;
    logic               r_t4_v;
    logic [2:0]         r_t4_sgn;
    logic [26:0]        r_t4_qm [3];
    qpat_pkg::t_quat    r_t4_err;
    logic               r_t5_v;
    logic [15:0]        r_t5_tq [3];
    qpat_pkg::t_quat    r_t5_err;

    logic [26:0]        w_lim [3];
    logic [26:0]        w_cap [3];
    logic [26:0]        w_m1  [3];
    logic [26:0]        w_m2  [3];
    logic [15:0]        w_tq  [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_lim[i] = 27'(r_lim[16*i +: 16]);
            w_cap[i] = r_t4_sgn[i] ? 27'd32768 : 27'd32767;
            w_m1[i]  = (r_t4_qm[i] > w_lim[i]) ? w_lim[i] : r_t4_qm[i];
            w_m2[i]  = (w_m1[i] > w_cap[i]) ? w_cap[i] : w_m1[i];
            w_tq[i]  = r_t4_sgn[i] ? (~w_m2[i][15:0] + 1'b1) : w_m2[i][15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t1_v <= 1'b0;
            r_t2_v <= 1'b0;
            r_t3_v <= 1'b0;
            r_t4_v <= 1'b0;
            r_t5_v <= 1'b0;
        end else if (w_en) begin
            r_t1_v <= w_e_v;
            r_t2_v <= r_t1_v;
            r_t3_v <= r_t2_v;
            r_t4_v <= r_t3_v;
            r_t5_v <= r_t4_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                r_t1_pp[i] <= $signed({1'b0, r_kp[i]}) * w_ev[i];
                r_t1_dd[i] <= $signed({1'b0, r_kd[i]}) * $signed(w_e_rate[16*i +: 16]);

                r_t2_t22[i] <= $signed({{2{r_t1_pp[i][32]}}, r_t1_pp[i], 1'b0})
                             - $signed({r_t1_dd[i][32], r_t1_dd[i], 2'b00});

                r_t3_sgn[i] <= r_t2_t22[i][35];
                r_t3_mag[i] <= r_t2_t22[i][35] ? (~r_t2_t22[i] + 1'b1) : r_t2_t22[i];

                // Round to the output scale, ties away from zero.
                r_t4_sgn[i] <= r_t3_sgn[i];
                r_t4_qm[i]  <= 27'((37'(r_t3_mag[i]) + 37'd512) >> 10);

                r_t5_tq[i]  <= w_tq[i];
            end
            r_t1_err <= w_e_q;
            r_t2_err <= r_t1_err;
            r_t3_err <= r_t2_err;
            r_t4_err <= r_t3_err;
            r_t5_err <= r_t4_err;
        end
    end

    // Output register with skid.
    logic            w_take;
    logic            r_o_v;
    logic [15:0]     r_o_tq [3];
    qpat_pkg::t_quat r_o_err;
    logic [15:0]     r_sk_tq [3];
    qpat_pkg::t_quat r_sk_err;

    assign w_take = w_en & r_t5_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_v  <= 1'b0;
            r_sk_v <= 1'b0;
        end else if (!r_o_v || i_ready) begin
            if (r_sk_v) begin
                r_o_v  <= 1'b1;
                r_sk_v <= 1'b0;
            end else begin
                r_o_v <= w_take;
            end
        end else if (w_take) begin
            r_sk_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_o_v || i_ready) begin
            if (r_sk_v) begin
                r_o_tq  <= r_sk_tq;
                r_o_err <= r_sk_err;
            end else if (w_take) begin
                r_o_tq  <= r_t5_tq;
                r_o_err <= r_t5_err;
            end
        end else if (w_take) begin
            r_sk_tq  <= r_t5_tq;
            r_sk_err <= r_t5_err;
        end
    end

    assign o_valid    = r_o_v;
    assign o_torque_x = r_o_tq[0];
    assign o_torque_y = r_o_tq[1];
    assign o_torque_z = r_o_tq[2];
    assign o_err_w    = r_o_err.w[14:0];
    assign o_err_x    = r_o_err.x;
    assign o_err_y    = r_o_err.y;
    assign o_err_z    = r_o_err.z;

endmodule
